### rtl/core/sscp_pkg.sv
`default_nettype none
package sscp_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int DIR_WIDTH       = COORD_WIDTH + 1;
    localparam int PROD_WIDTH      = 2 * DIR_WIDTH;
    localparam int DOT_WIDTH       = PROD_WIDTH + 2;
    localparam int HALF_WIDTH      = DOT_WIDTH / 2;
    localparam int WIDE_WIDTH      = 2 * DOT_WIDTH;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int PARAM_WIDTH     = PARAM_FRAC_BITS + 1;
    localparam int LERP_WIDTH      = DIR_WIDTH + PARAM_WIDTH + 1;
    localparam int DIST_WIDTH      = 50;
    localparam int CFG_WIDTH       = 32;
    localparam int CFG_ADDR_WIDTH  = 3;

    localparam logic [PARAM_WIDTH-1:0] PARAM_ONE = PARAM_WIDTH'(1) << PARAM_FRAC_BITS;
    localparam logic [CFG_WIDTH-1:0]   MIN_LEN_RESET = CFG_WIDTH'(200);
    localparam logic                   REG_MIN_LEN = 1'b0;

    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = PARAM_FRAC_BITS + 1;

    // pipeline cycle index of each register group after acceptance
    localparam int ST_DIFF = 1;
    localparam int ST_PROD = 2;
    localparam int ST_DOT  = 3;
    localparam int ST_LONG = ST_DOT + 1;
    localparam int ST_WIDE = ST_DOT + MUL_LAT;
    localparam int ST_DEN  = ST_WIDE + 1;
    localparam int ST_T1A  = ST_DEN + DIV_LAT;
    localparam int ST_VMUL = ST_T1A + MUL_LAT;
    localparam int ST_V    = ST_VMUL + 1;
    localparam int ST_SEL  = ST_V + 1;
    localparam int ST_TQ   = ST_SEL + DIV_LAT;
    localparam int ST_T    = ST_TQ + 1;
    localparam int ST_LP   = ST_T + 1;
    localparam int ST_PT   = ST_LP + 1;
    localparam int ST_SQ   = ST_PT + 1;
    localparam int ST_OUT  = ST_SQ + 1;
    localparam int PIPE_LATENCY = ST_OUT;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] pa;
        logic [2:0][COORD_WIDTH-1:0] pb;
        logic [2:0][DIR_WIDTH-1:0]   da;
        logic [2:0][DIR_WIDTH-1:0]   db;
    } t_geo;

    typedef struct packed {
        logic signed [DOT_WIDTH-1:0] aa;
        logic signed [DOT_WIDTH-1:0] bb;
        logic signed [DOT_WIDTH-1:0] ab;
        logic signed [DOT_WIDTH-1:0] ea;
        logic signed [DOT_WIDTH-1:0] eb;
    } t_dots;

    typedef struct packed {
        logic use_t1a;
        logic t2_one;
    } t_sel;

    function automatic logic signed [WIDE_WIDTH-1:0] widen(input logic signed [DOT_WIDTH-1:0] x);
        return {{(WIDE_WIDTH-DOT_WIDTH){x[DOT_WIDTH-1]}}, x};
    endfunction

endpackage
`default_nettype wire

### rtl/core/sscp_mul.sv
`default_nettype none
module sscp_mul (
    input  logic                                  i_clk,
    input  logic signed [sscp_pkg::DOT_WIDTH-1:0]  i_a,
    input  logic signed [sscp_pkg::DOT_WIDTH-1:0]  i_b,
    output logic signed [sscp_pkg::WIDE_WIDTH-1:0] o_p
);
    import sscp_pkg::*;

    localparam int PP_WIDTH = 2 * HALF_WIDTH + 2;

    logic [HALF_WIDTH-1:0] a_lo, a_hi, b_lo, b_hi;
    logic signed [PP_WIDTH-1:0] r_ll, r_lh, r_hl, r_hh;
    logic signed [WIDE_WIDTH-1:0] r_p;

    assign a_lo = i_a[HALF_WIDTH-1:0];
    assign a_hi = i_a[DOT_WIDTH-1:HALF_WIDTH];
    assign b_lo = i_b[HALF_WIDTH-1:0];
    assign b_hi = i_b[DOT_WIDTH-1:HALF_WIDTH];

    // partial products
    always_ff @(posedge i_clk) begin
        r_ll <= $signed({1'b0, a_lo}) * $signed({1'b0, b_lo});
        r_hl <= $signed({i_a[DOT_WIDTH-1], a_hi}) * $signed({1'b0, b_lo});
        r_lh <= $signed({1'b0, a_lo}) * $signed({i_b[DOT_WIDTH-1], b_hi});
        r_hh <= $signed({i_a[DOT_WIDTH-1], a_hi}) * $signed({i_b[DOT_WIDTH-1], b_hi});
    end

    always_ff @(posedge i_clk) begin
        r_p <= (WIDE_WIDTH'(r_hh) <<< (2 * HALF_WIDTH))
             + ((WIDE_WIDTH'(r_hl) + WIDE_WIDTH'(r_lh)) <<< HALF_WIDTH)
             + WIDE_WIDTH'(r_ll);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

### rtl/core/sscp_div.sv
`default_nettype none
module sscp_div (
    input  logic                                  i_clk,
    input  logic signed [sscp_pkg::WIDE_WIDTH-1:0] i_num,
    input  logic signed [sscp_pkg::WIDE_WIDTH-1:0] i_den,
    output logic [sscp_pkg::PARAM_WIDTH-1:0]       o_quot
);
    import sscp_pkg::*;

    localparam int STEPS = PARAM_FRAC_BITS;

    logic [WIDE_WIDTH-1:0]      r_rem [0:STEPS];
    logic [WIDE_WIDTH-1:0]      r_dvs [0:STEPS];
    logic [PARAM_FRAC_BITS-1:0] r_q   [0:STEPS];
    logic                       r_skip[0:STEPS];
    logic [PARAM_WIDTH-1:0]     r_fix [0:STEPS];
    logic                       is_zero, is_one;

    assign is_zero = (i_den <= 0) || (i_num <= 0);
    assign is_one  = !is_zero && (i_num >= i_den);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num;
        r_dvs[0]  <= i_den;
        r_q[0]    <= '0;
        r_skip[0] <= is_zero || is_one;
        r_fix[0]  <= is_one ? PARAM_ONE : '0;
    end

    // one restoring step per stage
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [WIDE_WIDTH-1:0] shifted;
        logic                  ge;
        assign shifted = {r_rem[k-1][WIDE_WIDTH-2:0], 1'b0};
        assign ge      = shifted >= r_dvs[k-1];
        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? shifted - r_dvs[k-1] : shifted;
            r_q[k]    <= {r_q[k-1][PARAM_FRAC_BITS-2:0], ge};
            r_dvs[k]  <= r_dvs[k-1];
            r_skip[k] <= r_skip[k-1];
            r_fix[k]  <= r_fix[k-1];
        end
    end

    assign o_quot = r_skip[STEPS] ? r_fix[STEPS] : {1'b0, r_q[STEPS]};

endmodule
`default_nettype wire

### rtl/core/segment_segment_closest_points.sv
`default_nettype none
// Closest points between two 3D segments. One transaction may be started on
// every clock cycle; busy stays low. Each result appears on the output ports
// for one cycle, marked by o_done, in order, and must be taken then since the
// receiver cannot stall. The latency is set by two ranks of 17-stage restoring
// dividers in series (the parameter on the first segment, then the clamped
// pair) and by two-stage wide multipliers that form the determinant before
// them and the projection in between.
module segment_segment_closest_points (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_start_x,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_start_y,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_start_z,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_end_x,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_end_y,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_end_z,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_start_x,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_start_y,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_start_z,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_end_x,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_end_y,
    input  logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_end_z,
    output logic                                   o_done,
    output logic [sscp_pkg::DIST_WIDTH-1:0]         o_dist_sq,
    output logic [sscp_pkg::PARAM_WIDTH-1:0]        o_param_a,
    output logic [sscp_pkg::PARAM_WIDTH-1:0]        o_param_b,
    output logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_a_x,
    output logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_a_y,
    output logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_a_z,
    output logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_b_x,
    output logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_b_y,
    output logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_b_z,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [sscp_pkg::CFG_ADDR_WIDTH-1:0]     paddr,
    input  logic [sscp_pkg::CFG_WIDTH-1:0]          pwdata,
    output logic [sscp_pkg::CFG_WIDTH-1:0]          prdata,
    output logic                                   pready
);
    import sscp_pkg::*;

    logic [CFG_WIDTH-1:0] r_min_len;
    logic                 r_vld [ST_DIFF:ST_OUT];

    t_geo  r_geo [ST_DIFF:ST_LP];
    logic [2:0][DIR_WIDTH-1:0] r_df;
    logic signed [PROD_WIDTH-1:0] r_pp [0:4][0:2];
    t_dots r_dots [ST_DOT:ST_V];
    logic  r_long_a [ST_LONG:ST_V];
    logic  r_long_b [ST_LONG:ST_V];

    logic signed [WIDE_WIDTH-1:0] m_aabb, m_abab, m_eabb, m_ebab, m_v;
    logic signed [WIDE_WIDTH-1:0] r_n1, r_den, r_v, r_lim;
    logic [PARAM_WIDTH-1:0] t1a, q1, q2;
    logic [PARAM_WIDTH-1:0] r_t1a [ST_T1A+1:ST_TQ];

    logic signed [WIDE_WIDTH-1:0] n_num1, n_den1, n_num2, n_den2;
    logic signed [WIDE_WIDTH-1:0] r_num1, r_den1, r_num2, r_den2;
    t_sel n_sel;
    t_sel r_sel [ST_SEL:ST_TQ];

    logic [PARAM_WIDTH-1:0] r_t1 [ST_T:ST_SQ];
    logic [PARAM_WIDTH-1:0] r_t2 [ST_T:ST_SQ];
    logic signed [LERP_WIDTH-1:0] r_lpa [0:2];
    logic signed [LERP_WIDTH-1:0] r_lpb [0:2];
    logic signed [LERP_WIDTH-1:0] pt_a [0:2];
    logic signed [LERP_WIDTH-1:0] pt_b [0:2];
    logic [2:0][COORD_WIDTH-1:0] r_ca [ST_PT:ST_SQ];
    logic [2:0][COORD_WIDTH-1:0] r_cb [ST_PT:ST_SQ];
    logic [PROD_WIDTH-1:0] r_sq [0:2];
    logic [DIST_WIDTH-1:0] r_dist;
    logic [PARAM_WIDTH-1:0] r_out_a, r_out_b;
    logic [2:0][COORD_WIDTH-1:0] r_out_ca, r_out_cb;

    logic [2:0][COORD_WIDTH-1:0] in_as, in_ae, in_bs, in_be;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_LEN) begin
            r_min_len <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_MIN_LEN) ? r_min_len : '0;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = ST_DIFF; k <= ST_OUT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[ST_DIFF] <= start;
            for (int k = ST_DIFF + 1; k <= ST_OUT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    assign in_as = {i_a_start_z, i_a_start_y, i_a_start_x};
    assign in_ae = {i_a_end_z, i_a_end_y, i_a_end_x};
    assign in_bs = {i_b_start_z, i_b_start_y, i_b_start_x};
    assign in_be = {i_b_end_z, i_b_end_y, i_b_end_x};

    // directions and offset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_geo[ST_DIFF].pa[i] <= in_as[i];
            r_geo[ST_DIFF].pb[i] <= in_bs[i];
            r_geo[ST_DIFF].da[i] <= DIR_WIDTH'($signed(in_ae[i])) - DIR_WIDTH'($signed(in_as[i]));
            r_geo[ST_DIFF].db[i] <= DIR_WIDTH'($signed(in_be[i])) - DIR_WIDTH'($signed(in_bs[i]));
            r_df[i]              <= DIR_WIDTH'($signed(in_bs[i])) - DIR_WIDTH'($signed(in_as[i]));
        end
        for (int k = ST_DIFF + 1; k <= ST_LP; k++) r_geo[k] <= r_geo[k-1];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pp[0][i] <= $signed(r_geo[ST_DIFF].da[i]) * $signed(r_geo[ST_DIFF].da[i]);
            r_pp[1][i] <= $signed(r_geo[ST_DIFF].db[i]) * $signed(r_geo[ST_DIFF].db[i]);
            r_pp[2][i] <= $signed(r_geo[ST_DIFF].da[i]) * $signed(r_geo[ST_DIFF].db[i]);
            r_pp[3][i] <= $signed(r_df[i]) * $signed(r_geo[ST_DIFF].da[i]);
            r_pp[4][i] <= $signed(r_df[i]) * $signed(r_geo[ST_DIFF].db[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dots[ST_DOT].aa <= DOT_WIDTH'(r_pp[0][0]) + DOT_WIDTH'(r_pp[0][1]) + DOT_WIDTH'(r_pp[0][2]);
        r_dots[ST_DOT].bb <= DOT_WIDTH'(r_pp[1][0]) + DOT_WIDTH'(r_pp[1][1]) + DOT_WIDTH'(r_pp[1][2]);
        r_dots[ST_DOT].ab <= DOT_WIDTH'(r_pp[2][0]) + DOT_WIDTH'(r_pp[2][1]) + DOT_WIDTH'(r_pp[2][2]);
        r_dots[ST_DOT].ea <= DOT_WIDTH'(r_pp[3][0]) + DOT_WIDTH'(r_pp[3][1]) + DOT_WIDTH'(r_pp[3][2]);
        r_dots[ST_DOT].eb <= DOT_WIDTH'(r_pp[4][0]) + DOT_WIDTH'(r_pp[4][1]) + DOT_WIDTH'(r_pp[4][2]);
        for (int k = ST_DOT + 1; k <= ST_V; k++) r_dots[k] <= r_dots[k-1];
    end

    // segment length classification
    always_ff @(posedge i_clk) begin
        r_long_a[ST_LONG] <= r_dots[ST_DOT].aa >= $signed({{(DOT_WIDTH-CFG_WIDTH){1'b0}}, r_min_len});
        r_long_b[ST_LONG] <= r_dots[ST_DOT].bb >= $signed({{(DOT_WIDTH-CFG_WIDTH){1'b0}}, r_min_len});
        for (int k = ST_LONG + 1; k <= ST_V; k++) begin
            r_long_a[k] <= r_long_a[k-1];
            r_long_b[k] <= r_long_b[k-1];
        end
    end

    sscp_mul u_mul_aabb (.i_clk, .i_a(r_dots[ST_DOT].aa), .i_b(r_dots[ST_DOT].bb), .o_p(m_aabb));
    sscp_mul u_mul_abab (.i_clk, .i_a(r_dots[ST_DOT].ab), .i_b(r_dots[ST_DOT].ab), .o_p(m_abab));
    sscp_mul u_mul_eabb (.i_clk, .i_a(r_dots[ST_DOT].ea), .i_b(r_dots[ST_DOT].bb), .o_p(m_eabb));
    sscp_mul u_mul_ebab (.i_clk, .i_a(r_dots[ST_DOT].eb), .i_b(r_dots[ST_DOT].ab), .o_p(m_ebab));

    always_ff @(posedge i_clk) begin
        r_n1  <= m_eabb - m_ebab;
        r_den <= m_aabb - m_abab;
    end

    sscp_div u_div_t1a (.i_clk, .i_num(r_n1), .i_den(r_den), .o_quot(t1a));

    sscp_mul u_mul_v (
        .i_clk,
        .i_a({{(DOT_WIDTH-PARAM_WIDTH){1'b0}}, t1a}),
        .i_b(r_dots[ST_T1A].ab),
        .o_p(m_v)
    );

    always_ff @(posedge i_clk) begin
        r_t1a[ST_T1A+1] <= t1a;
        for (int k = ST_T1A + 2; k <= ST_TQ; k++) r_t1a[k] <= r_t1a[k-1];
    end

    always_ff @(posedge i_clk) begin
        r_v   <= m_v - (widen(r_dots[ST_VMUL].eb) <<< PARAM_FRAC_BITS);
        r_lim <= widen(r_dots[ST_VMUL].bb) <<< PARAM_FRAC_BITS;
    end

    // pick the dividends and divisors of the final quotients for each case
    always_comb begin
        n_num1 = '0;
        n_den1 = widen(r_dots[ST_V].aa);
        n_num2 = '0;
        n_den2 = r_lim;
        n_sel  = '0;
        priority if (r_long_a[ST_V] && r_long_b[ST_V]) begin
            priority if (r_v <= 0) begin
                n_num1 = widen(r_dots[ST_V].ea);
            end else if (r_v >= r_lim) begin
                n_num1       = widen(r_dots[ST_V].ea) + widen(r_dots[ST_V].ab);
                n_sel.t2_one = 1'b1;
            end else begin
                n_num2        = r_v;
                n_sel.use_t1a = 1'b1;
            end
        end else if (r_long_a[ST_V]) begin
            n_num1 = widen(r_dots[ST_V].ea);
        end else if (r_long_b[ST_V]) begin
            n_num2 = -widen(r_dots[ST_V].eb);
            n_den2 = widen(r_dots[ST_V].bb);
        end else begin
            n_num1 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num1 <= n_num1;
        r_den1 <= n_den1;
        r_num2 <= n_num2;
        r_den2 <= n_den2;
        r_sel[ST_SEL] <= n_sel;
        for (int k = ST_SEL + 1; k <= ST_TQ; k++) r_sel[k] <= r_sel[k-1];
    end

    sscp_div u_div_t1 (.i_clk, .i_num(r_num1), .i_den(r_den1), .o_quot(q1));
    sscp_div u_div_t2 (.i_clk, .i_num(r_num2), .i_den(r_den2), .o_quot(q2));

    always_ff @(posedge i_clk) begin
        r_t1[ST_T] <= r_sel[ST_TQ].use_t1a ? r_t1a[ST_TQ] : q1;
        r_t2[ST_T] <= r_sel[ST_TQ].t2_one ? PARAM_ONE : q2;
        for (int k = ST_T + 1; k <= ST_SQ; k++) begin
            r_t1[k] <= r_t1[k-1];
            r_t2[k] <= r_t2[k-1];
        end
    end

    // closest points
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_lpa[i] <= $signed(r_geo[ST_T].da[i]) * $signed({1'b0, r_t1[ST_T]});
            r_lpb[i] <= $signed(r_geo[ST_T].db[i]) * $signed({1'b0, r_t2[ST_T]});
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt_a[i] = LERP_WIDTH'($signed(r_geo[ST_LP].pa[i])) + (r_lpa[i] >>> PARAM_FRAC_BITS);
            pt_b[i] = LERP_WIDTH'($signed(r_geo[ST_LP].pb[i])) + (r_lpb[i] >>> PARAM_FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_ca[ST_PT][i] <= pt_a[i][COORD_WIDTH-1:0];
            r_cb[ST_PT][i] <= pt_b[i][COORD_WIDTH-1:0];
        end
        r_ca[ST_SQ] <= r_ca[ST_PT];
        r_cb[ST_SQ] <= r_cb[ST_PT];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= PROD_WIDTH'(
                (DIR_WIDTH'($signed(r_ca[ST_PT][i])) - DIR_WIDTH'($signed(r_cb[ST_PT][i])))
              * (DIR_WIDTH'($signed(r_ca[ST_PT][i])) - DIR_WIDTH'($signed(r_cb[ST_PT][i]))));
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist   <= DIST_WIDTH'(r_sq[0] + r_sq[1] + r_sq[2]);
        r_out_a  <= r_t1[ST_SQ];
        r_out_b  <= r_t2[ST_SQ];
        r_out_ca <= r_ca[ST_SQ];
        r_out_cb <= r_cb[ST_SQ];
    end

    assign o_done     = r_vld[ST_OUT];
    assign o_dist_sq  = r_dist;
    assign o_param_a  = r_out_a;
    assign o_param_b  = r_out_b;
    assign o_near_a_x = r_out_ca[0];
    assign o_near_a_y = r_out_ca[1];
    assign o_near_a_z = r_out_ca[2];
    assign o_near_b_x = r_out_cb[0];
    assign o_near_b_y = r_out_cb[1];
    assign o_near_b_z = r_out_cb[2];

endmodule
`default_nettype wire

### rtl/core/sscp_check.sv
`default_nettype none
module sscp_check (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   o_done,
    input logic [sscp_pkg::PARAM_WIDTH-1:0]        o_param_a,
    input logic [sscp_pkg::PARAM_WIDTH-1:0]        o_param_b,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_start_x,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_start_y,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] i_a_start_z,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_start_x,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_start_y,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] i_b_start_z,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_a_x,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_a_y,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_a_z,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_b_x,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_b_y,
    input logic signed [sscp_pkg::COORD_WIDTH-1:0] o_near_b_z
);
    import sscp_pkg::*;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LATENCY o_done)
        else $error("transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without transaction");

    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_param_a <= PARAM_ONE && o_param_b <= PARAM_ONE))
        else $error("parameter above one");

    a_near_a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_param_a == '0) |->
            (o_near_a_x == $past(i_a_start_x, PIPE_LATENCY)
          && o_near_a_y == $past(i_a_start_y, PIPE_LATENCY)
          && o_near_a_z == $past(i_a_start_z, PIPE_LATENCY)))
        else $error("zero parameter point off first start");

    a_near_b_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_param_b == '0) |->
            (o_near_b_x == $past(i_b_start_x, PIPE_LATENCY)
          && o_near_b_y == $past(i_b_start_y, PIPE_LATENCY)
          && o_near_b_z == $past(i_b_start_z, PIPE_LATENCY)))
        else $error("zero parameter point off second start");

endmodule

bind segment_segment_closest_points sscp_check u_check (.*);
`default_nettype wire
